// ===== hdl/sccfd_pkg.sv =====
// Package for the two-byte-sync checksum frame deframer.
// Holds field widths, frame geometry, register reset values and register indexes.
// No dependencies.
package sccfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;

    // Frame geometry: the second sync byte is frame byte one, the payload
    // follows, and the check byte sits at frame byte twelve.
    localparam int          PAYLOAD_LEN = 10;
    localparam int          COUNT_W     = 4;
    localparam int          IDX_W       = 4;
    localparam logic [3:0]  CHECK_POS   = 4'd12;
    localparam logic [3:0]  FIRST_PAY   = 4'd2;

    // Register reset values
    localparam logic [7:0] FIRST_SYNC_RST = 8'hAA;
    localparam logic [7:0] SECOND_SYNC_RST = 8'hBB;
    localparam logic [7:0] SEED_RST = 8'h65;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SYNC  = 2'd0,
        CFG_SECOND_SYNC = 2'd1,
        CFG_SEED        = 2'd2
    } t_cfg_idx;

endpackage

// ===== hdl/sync_checksum_frame_deframer_top.sv =====
// Top level of the two-byte-sync checksum frame deframer.
// Depends on sccfd_pkg (widths, frame geometry, register indexes).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_rx_byte) takes one received
//   byte per transaction. The block hunts for the first sync byte, then waits
//   for the second sync byte (other bytes in that wait are ignored), then
//   collects ten payload bytes into a modulo-256 sum seeded from the seed
//   register. The next byte is the check byte: on a match one result
//   transaction carries five big-endian 16-bit values (raw tenths) on the
//   output channel (o_out_valid / i_out_stall / o_value_a..e); on a mismatch
//   the frame is dropped silently. Either way the block returns to hunting.
//   Result: registered, so it appears in the cycle after the check byte is accepted.
//   Throughput: one byte per cycle; every byte updates a few small registers
//   between the input handshake and the result register, so nothing limits
//   the rate but the output register when it is held.
//   Stall: while a result waits in the output register under i_out_stall,
//   o_in_stall is raised, since the next byte could complete another frame.
//   When the output register is empty or drains this cycle, bytes keep
//   flowing.
//   Reset (i_rst_n low, synchronous): registers go to 0xAA / 0xBB / 0x65,
//   the framer goes to hunting and the output register is emptied.
//   Configuration: write i_cfg_we / i_cfg_idx / i_cfg_data only while idle;
//   an index beyond the three registers is ignored.
module sync_checksum_frame_deframer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sccfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sccfd_pkg::BYTE_W-1:0]        i_cfg_data,
    // input byte channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sccfd_pkg::BYTE_W-1:0]        i_rx_byte,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sccfd_pkg::VALUE_W-1:0]       o_value_a,
    output logic [sccfd_pkg::VALUE_W-1:0]       o_value_b,
    output logic [sccfd_pkg::VALUE_W-1:0]       o_value_c,
    output logic [sccfd_pkg::VALUE_W-1:0]       o_value_d,
    output logic [sccfd_pkg::VALUE_W-1:0]       o_value_e
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_HALF  = 2'd1,
        PH_FRAME = 2'd2
    } t_phase;

    // configuration registers
    logic [sccfd_pkg::BYTE_W-1:0] r_first_sync;
    logic [sccfd_pkg::BYTE_W-1:0] r_second_sync;
    logic [sccfd_pkg::BYTE_W-1:0] r_seed;

    // framer state
    t_phase                          r_phase, n_phase;
    logic [sccfd_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [sccfd_pkg::BYTE_W-1:0]    r_sum, n_sum;
    logic [sccfd_pkg::BYTE_W-1:0]    r_store [sccfd_pkg::PAYLOAD_LEN];

    // result register
    logic                            r_out_valid;
    logic [sccfd_pkg::VALUE_W-1:0]   r_value [5];

    logic                            in_accept;
    logic                            emit;
    logic                            store_we;
    logic [sccfd_pkg::COUNT_W-1:0]   count_inc;
    logic [sccfd_pkg::IDX_W-1:0]     store_idx;

    // Hold input while a finished result is stuck in the output register.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_accept  = i_in_valid & ~o_in_stall;

    assign count_inc = r_count + sccfd_pkg::COUNT_W'(1);
    assign store_idx = count_inc - sccfd_pkg::FIRST_PAY;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        emit     = 1'b0;
        store_we = 1'b0;
        if (in_accept) begin
            unique case (r_phase)
                PH_FRAME: begin
                    if (count_inc == sccfd_pkg::CHECK_POS) begin
                        // check byte: compare, then return to hunting
                        emit    = (i_rx_byte == r_sum);
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end else begin
                        n_count  = count_inc;
                        store_we = (count_inc >= sccfd_pkg::FIRST_PAY) &&
                                   (store_idx < sccfd_pkg::IDX_W'(sccfd_pkg::PAYLOAD_LEN));
                        n_sum    = r_sum + i_rx_byte;
                    end
                end
                PH_HALF: begin
                    // other bytes are ignored while waiting for the second sync
                    if (i_rx_byte == r_second_sync) begin
                        n_phase = PH_FRAME;
                        n_count = sccfd_pkg::COUNT_W'(1);
                        n_sum   = r_seed;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == r_first_sync) ? PH_HALF : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= sccfd_pkg::FIRST_SYNC_RST;
            r_second_sync <= sccfd_pkg::SECOND_SYNC_RST;
            r_seed        <= sccfd_pkg::SEED_RST;
            r_phase       <= PH_HUNT;
            r_count       <= '0;
            r_sum         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sccfd_pkg::CFG_FIRST_SYNC:  r_first_sync  <= i_cfg_data;
                    sccfd_pkg::CFG_SECOND_SYNC: r_second_sync <= i_cfg_data;
                    sccfd_pkg::CFG_SEED:        r_seed        <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload store and result values carry no reset.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_idx] <= i_rx_byte;
        end
        if (emit) begin
            for (int k = 0; k < 5; k++) begin
                r_value[k] <= {r_store[2*k], r_store[2*k+1]};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_a   = r_value[0];
    assign o_value_b   = r_value[1];
    assign o_value_c   = r_value[2];
    assign o_value_d   = r_value[3];
    assign o_value_e   = r_value[4];

endmodule

// ===== hdl/sccfd_checker.sv =====
// Port-level checker for the two-byte-sync checksum frame deframer.
// Depends on sccfd_pkg; bound to sync_checksum_frame_deframer_top below.
module sccfd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [sccfd_pkg::VALUE_W-1:0]     o_value_a,
    input logic [sccfd_pkg::VALUE_W-1:0]     o_value_e
);

    // a held result keeps its valid and its value_a and value_e payload
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_value_a) && $stable(o_value_e))
        else $error("result payload changed while stalled");

    // input is only held back by a stuck result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a pending result");

    // a new result needs a byte accepted the cycle before
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result without an accepted byte");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sync_checksum_frame_deframer_top sccfd_checker u_sccfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value_a   (o_value_a),
    .o_value_e   (o_value_e)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for sync_checksum_frame_deframer_top.
// Depends on sccfd_pkg and the deframer RTL; drives framed byte streams under
// random flow control and checks each decoded frame against a local predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 4;     // result lands in the cycle after the check byte
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    // no register behind this index
    localparam logic [sccfd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SYNC_HUNT,
        SYNC_HALF,
        SYNC_FRAME
    } t_sync_state;

    // [0] is value_a ... [4] is value_e
    typedef logic [4:0][sccfd_pkg::VALUE_W-1:0] t_frame_vals;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [sccfd_pkg::CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [sccfd_pkg::BYTE_W-1:0]      cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [sccfd_pkg::BYTE_W-1:0]      rx_byte = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [sccfd_pkg::VALUE_W-1:0]     value_a, value_b, value_c, value_d, value_e;

    sync_checksum_frame_deframer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_rx_byte   (rx_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_value_a   (value_a),
        .o_value_b   (value_b),
        .o_value_c   (value_c),
        .o_value_d   (value_d),
        .o_value_e   (value_e)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Bytes waiting to be sent and frames waiting to come out.
    logic [sccfd_pkg::BYTE_W-1:0] rx_stream_q[$];
    t_frame_vals                  decoded_q[$];

    // Register copies as the block should hold them.
    logic [sccfd_pkg::BYTE_W-1:0] cfg_first = sccfd_pkg::FIRST_SYNC_RST;
    logic [sccfd_pkg::BYTE_W-1:0] cfg_second = sccfd_pkg::SECOND_SYNC_RST;
    logic [sccfd_pkg::BYTE_W-1:0] cfg_seed = sccfd_pkg::SEED_RST;

    // Deframer state as predicted.
    t_sync_state                   sync_state = SYNC_HUNT;
    logic [sccfd_pkg::COUNT_W-1:0] frame_pos = '0;
    logic [sccfd_pkg::BYTE_W-1:0]  frame_sum = '0;
    logic [sccfd_pkg::BYTE_W-1:0]  payload_mem [sccfd_pkg::PAYLOAD_LEN];

    // payload of the next queued frame
    logic [sccfd_pkg::BYTE_W-1:0] body_bytes [sccfd_pkg::PAYLOAD_LEN];
    int                frame_bytes = 0;            // well-formed or broken frame bytes queued
    int                mismatches = 0;
    int                cycle_count = 0;
    bit                steady_flow = 1'b0;         // both sides run without idling
    logic              hold_kick = 1'b0;
    int                hold_left = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic string value_name(input int k);
        case (k)
            0: return "value_a";
            1: return "value_b";
            2: return "value_c";
            3: return "value_d";
            default: return "value_e";
        endcase
    endfunction

    // Advance the predicted deframer by one accepted byte; queue a frame on a good check.
    task automatic advance_deframer(input logic [sccfd_pkg::BYTE_W-1:0] b);
        t_frame_vals vals;
        int k;
        case (sync_state)
            SYNC_FRAME: begin
                frame_pos = frame_pos + 1'b1;
                if (frame_pos == sccfd_pkg::CHECK_POS) begin
                    sync_state = SYNC_HUNT;
                    frame_pos = '0;
                    if (b == frame_sum) begin
                        for (k = 0; k < 5; k++)
                            vals[k] = {payload_mem[2*k], payload_mem[2*k+1]};
                        decoded_q.push_back(vals);
                    end
                end else begin
                    if (frame_pos >= sccfd_pkg::FIRST_PAY &&
                        int'(frame_pos - sccfd_pkg::FIRST_PAY) < sccfd_pkg::PAYLOAD_LEN)
                        payload_mem[frame_pos - sccfd_pkg::FIRST_PAY] = b;
                    frame_sum = frame_sum + b;
                end
            end
            SYNC_HALF: begin
                // anything but the second sync byte is ignored here
                if (b == cfg_second) begin
                    sync_state = SYNC_FRAME;
                    frame_pos = 4'd1;
                    frame_sum = cfg_seed;
                end
            end
            default: sync_state = (b == cfg_first) ? SYNC_HALF : SYNC_HUNT;
        endcase
    endtask

    // Queue one frame built from the current register values.
    task automatic queue_frame(input bit good, input int junk, input bit fresh_body);
        logic [sccfd_pkg::BYTE_W-1:0] sum;
        logic [sccfd_pkg::BYTE_W-1:0] j;
        int k;
        rx_stream_q.push_back(cfg_first);
        for (k = 0; k < junk; k++) begin
            j = 8'($urandom);
            if (j == cfg_second)
                j = ~j;
            rx_stream_q.push_back(j);
        end
        rx_stream_q.push_back(cfg_second);
        sum = cfg_seed;
        for (k = 0; k < sccfd_pkg::PAYLOAD_LEN; k++) begin
            if (fresh_body)
                body_bytes[k] = 8'($urandom);
            rx_stream_q.push_back(body_bytes[k]);
            sum = sum + body_bytes[k];
        end
        rx_stream_q.push_back(good ? sum : sum ^ 8'($urandom_range(1, 255)));
        frame_bytes += 2 + junk + sccfd_pkg::PAYLOAD_LEN + 1;
    endtask

    // Mostly good frames with random bodies, some bad checks, cut-off frames and noise.
    task automatic queue_random(input int n);
        int target;
        int pick;
        int k;
        int cut;
        target = frame_bytes + n;
        while (frame_bytes < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                queue_frame(1'b1, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
            end else if (pick < 15) begin
                queue_frame(1'b0, 0, 1'b1);
            end else if (pick < 17) begin
                // cut the frame short, then let filler bytes run it out
                cut = $urandom_range(1, sccfd_pkg::PAYLOAD_LEN);
                rx_stream_q.push_back(cfg_first);
                rx_stream_q.push_back(cfg_second);
                for (k = 0; k < cut + 11; k++)
                    rx_stream_q.push_back(8'($urandom));
                frame_bytes += cut + 13;
            end else begin
                repeat ($urandom_range(1, 6))
                    rx_stream_q.push_back(8'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [sccfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sccfd_pkg::BYTE_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            sccfd_pkg::CFG_FIRST_SYNC:  cfg_first = data;
            sccfd_pkg::CFG_SECOND_SYNC: cfg_second = data;
            sccfd_pkg::CFG_SEED:        cfg_seed = data;
            default: ;       // spare index: no register
        endcase
    endtask

    // Wait until every byte is accepted and every frame has come out, then settle.
    task automatic wait_for_quiet;
        while (rx_stream_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps. A payload
    // under stall holds until its transaction completes.
    int gap_left = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin : drive_proc
        bit offer;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            rx_byte <= '0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            offer = !in_valid;
            if (in_valid && !in_stall) begin
                advance_deframer(rx_byte);
                rx_stream_q.delete(0);
                offer = 1'b1;
                if (burst_left != 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = (steady_flow || $urandom_range(0, 2) == 0) ? 0
                                                                          : $urandom_range(1, 6);
                end
            end
            if (offer) begin
                if (gap_left != 0) begin
                    in_valid <= 1'b0;
                    gap_left--;
                end else if (rx_stream_q.size() != 0) begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_stream_q[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the block fills up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: rotate a stall pattern, reloaded with a fresh density whenever the 6-bit age counter wraps.
    logic [15:0] stall_pat = '0;
    logic [5:0]  pat_age = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_pat <= '0;
            pat_age <= '0;
        end else begin
            pat_age <= pat_age + 1'b1;
            if (pat_age == '0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat <= '0;
                    1: stall_pat <= 16'($urandom);
                    2: stall_pat <= 16'($urandom & $urandom);
                    default: stall_pat <= 16'($urandom | $urandom);
                endcase
            end else begin
                stall_pat <= {stall_pat[14:0], stall_pat[15]};
            end
            out_stall <= (hold_left != 0) || (!steady_flow && stall_pat[15]);
        end
    end

    // Monitor: compare each completed result transaction with the oldest predicted frame.
    always @(posedge i_clk) begin : check_proc
        t_frame_vals got;
        t_frame_vals want;
        int k;
        if (i_rst_n && out_valid && !out_stall) begin
            got = {value_e, value_d, value_c, value_b, value_a};
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected frame, value_a=%h", value_a));
            end else begin
                want = decoded_q.pop_front();
                for (k = 0; k < 5; k++)
                    if (got[k] !== want[k])
                        report_mismatch($sformatf("%s got %h want %h",
                                                  value_name(k), got[k], want[k]));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        logic [sccfd_pkg::BYTE_W-1:0] v;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes and sync values inside the payload, checksum wrap.
        body_bytes = '{8'h00, 8'hFF, cfg_first, cfg_second, 8'h00,
                       8'hFF, 8'hFF, 8'h00, cfg_second, cfg_first};
        queue_frame(1'b1, 0, 1'b0);
        // Repeated first sync and a stray byte while waiting for the second;
        // the frame then carries a wrong check byte and must be dropped.
        rx_stream_q.push_back(cfg_first);
        queue_frame(1'b0, 1, 1'b1);
        queue_random(150);
        wait_for_quiet();

        // Low extreme on first sync and seed, high on second; spare index ignored.
        write_reg(sccfd_pkg::CFG_FIRST_SYNC, 8'h00);
        write_reg(sccfd_pkg::CFG_SECOND_SYNC, 8'hFF);
        write_reg(sccfd_pkg::CFG_SEED, 8'h00);
        write_reg(CFG_SPARE, 8'($urandom));
        queue_random(150);
        wait_for_quiet();

        // Opposite extremes, no idling on either side.
        write_reg(sccfd_pkg::CFG_FIRST_SYNC, 8'hFF);
        write_reg(sccfd_pkg::CFG_SECOND_SYNC, 8'h00);
        write_reg(sccfd_pkg::CFG_SEED, 8'hFF);
        steady_flow = 1'b1;
        queue_random(120);
        wait_for_quiet();
        steady_flow = 1'b0;

        // Both sync bytes equal.
        v = 8'($urandom);
        write_reg(sccfd_pkg::CFG_FIRST_SYNC, v);
        write_reg(sccfd_pkg::CFG_SECOND_SYNC, v);
        write_reg(sccfd_pkg::CFG_SEED, 8'($urandom));
        queue_random(120);
        wait_for_quiet();

        // Random registers with a long receiver hold-off while bytes keep coming.
        write_reg(sccfd_pkg::CFG_FIRST_SYNC, 8'($urandom));
        write_reg(sccfd_pkg::CFG_SECOND_SYNC, 8'($urandom));
        write_reg(sccfd_pkg::CFG_SEED, 8'($urandom));
        queue_random(150);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        wait_for_quiet();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sccfd_pkg.sv
hdl/sync_checksum_frame_deframer_top.sv
hdl/sccfd_checker.sv
bench/tb_top.sv
